### design/anc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anc_pkg: shared types and constants for the neighbor cache
// Slot state codes, command codes and the word that moves from front to back.
// ----------------------------------------------------------------------------
package anc_pkg;

  localparam logic [1:0] ST_FREE       = 2'd0;
  localparam logic [1:0] ST_INCOMPLETE = 2'd1;
  localparam logic [1:0] ST_REACHABLE  = 2'd2;
  localparam logic [1:0] ST_FAILED     = 2'd3;

  localparam logic [1:0] CMD_RESOLVE = 2'd0;
  localparam logic [1:0] CMD_LEARN   = 2'd1;
  localparam logic [1:0] CMD_SWEEP   = 2'd2;
  localparam logic [1:0] CMD_RSVD    = 2'd3;

  localparam logic [1:0] CFG_LIFETIME = 2'd0;
  localparam logic [1:0] CFG_INTERVAL = 2'd1;
  localparam logic [1:0] CFG_HOLDOFF  = 2'd2;
  localparam logic [1:0] CFG_LIMIT    = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] target_ip;
    logic [47:0] learned_mac;
    logic [63:0] now_ticks;
  } cmd_word_t;

  typedef struct packed {
    logic        resolved;
    logic [47:0] resolved_mac;
    logic        send_probe;
    logic        table_full;
    logic [6:0]  live_entries;
  } rsp_word_t;

  // true when at least span ticks have passed since then, or then lies after now
  function automatic logic aged(input logic [63:0] now, input logic [63:0] then_t,
                                input logic [47:0] span);
    logic [63:0] diff;
    diff = now - then_t;
    return (now < then_t) || (diff >= {16'd0, span});
  endfunction

endpackage

### design/anc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anc_front: command intake
// Accept words, zero the learned MAC unless the command is a learn, push into a queue.
// ----------------------------------------------------------------------------
module anc_front #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic [31:0]        in_target_ip,
  input  logic [47:0]        in_learned_mac,
  input  logic [63:0]        in_now_ticks,
  output logic               q_valid,
  input  logic               q_pop,
  output anc_pkg::cmd_word_t q_word
);
  import anc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_word_t     mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  cmd_word_t     w;
  logic          push;

  always_comb begin
    w.command     = in_command;
    w.target_ip   = in_target_ip;
    w.now_ticks   = in_now_ticks;
    w.learned_mac = (in_command == CMD_LEARN) ? in_learned_mac : 48'd0;
  end

  assign in_ready = (cnt_r != (AW+1)'(DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_word   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
    end
    if (q_pop && q_valid) begin
      rp_nxt = (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
    end
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(q_pop && q_valid);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= w;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule

### design/anc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anc_back: table engine
// Walk the slot table entry by entry for lookup, allocation and sweep.
// ----------------------------------------------------------------------------
module anc_back #(
  parameter int ENTRIES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  anc_pkg::cmd_word_t q_word,
  input  logic [47:0]        lifetime,
  input  logic [47:0]        interval,
  input  logic [47:0]        holdoff,
  input  logic [7:0]         limit,
  output logic               out_valid,
  input  logic               out_ready,
  output anc_pkg::rsp_word_t out_word
);
  import anc_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_LOOKW, S_ACT, S_ALLOC, S_ALLOCW, S_LRU,
    S_CREATE, S_SWEEP, S_SWEEPW, S_DONE
  } fsm_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [63:0] conf_t;
    logic [63:0] probe_t;
    logic [63:0] used_t;
    logic [7:0]  cnt;
  } slot_t;

  // state bits live in flip-flops (cleared at reset); the rest in a memory
  logic [1:0]  st_r [ENTRIES];
  slot_t       mem [ENTRIES];
  slot_t       rd_r;

  fsm_t        fsm_r;
  cmd_word_t   cmd_r;
  logic [IW:0] idx_r;
  logic [IW-1:0] hit_r, lru_r, tgt_r;
  logic        hit_ok_r, lru_ok_r;
  logic [63:0] lru_t_r;
  logic [CW-1:0] count_r;
  rsp_word_t   rsp_r;
  logic        outv_r;

  logic        we;
  logic [IW-1:0] wa, ra;
  slot_t       wd;

  logic [IW-1:0] idx;
  assign idx = idx_r[IW-1:0];

  // one read port, one write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= mem[ra];
  end

  assign q_pop     = (fsm_r == S_IDLE) && q_valid && !outv_r;
  assign out_valid = outv_r;
  assign out_word  = rsp_r;

  logic rd_fresh, rd_fail_old, rd_probe_due, rd_below_limit, rd_same_mac;
  assign rd_fresh       = !aged(cmd_r.now_ticks, rd_r.conf_t, lifetime);
  assign rd_fail_old    = aged(cmd_r.now_ticks, rd_r.probe_t, holdoff);
  assign rd_probe_due   = aged(cmd_r.now_ticks, rd_r.probe_t, interval);
  assign rd_below_limit = (rd_r.cnt < limit);
  assign rd_same_mac    = (st_r[tgt_r] == ST_REACHABLE) && (rd_r.mac == cmd_r.learned_mac);

  // memory read address, and the write for the clearing pass and for the slot update of a command
  always_comb begin
    we = 1'b0;
    wa = tgt_r;
    wd = rd_r;
    unique case (fsm_r)
      S_ACT:   ra = hit_r;
      S_LRU:   ra = lru_r;
      default: ra = idx;
    endcase
    if (fsm_r == S_CLEAR) begin
      we = 1'b1;
      wa = idx;
      wd = '0;
    end else if (fsm_r == S_CREATE) begin
      if (!hit_ok_r) begin
        // new slot
        we = 1'b1;
        if (cmd_r.command == CMD_LEARN) begin
          wd = '{st: ST_REACHABLE, ip: cmd_r.target_ip, mac: cmd_r.learned_mac,
                 conf_t: cmd_r.now_ticks, probe_t: 64'd0, used_t: cmd_r.now_ticks,
                 cnt: 8'd0};
        end else begin
          wd = '{st: ST_INCOMPLETE, ip: cmd_r.target_ip, mac: 48'd0,
                 conf_t: 64'd0, probe_t: cmd_r.now_ticks,
                 used_t: cmd_r.now_ticks, cnt: 8'd1};
        end
      end else if (cmd_r.command == CMD_LEARN) begin
        we        = 1'b1;
        wd.conf_t = cmd_r.now_ticks;
        wd.used_t = cmd_r.now_ticks;
        if (!rd_same_mac) begin
          wd.st  = ST_REACHABLE;
          wd.mac = cmd_r.learned_mac;
          wd.cnt = '0;
        end
      end else if (st_r[tgt_r] == ST_REACHABLE) begin
        if (rd_fresh) begin
          we        = 1'b1;
          wd.used_t = cmd_r.now_ticks;
        end
      end else if (st_r[tgt_r] == ST_INCOMPLETE) begin
        if (rd_probe_due) begin
          we         = 1'b1;
          wd.probe_t = cmd_r.now_ticks;
          if (rd_below_limit) begin
            wd.cnt = rd_r.cnt + 8'd1;
          end
        end
      end else if (rd_fail_old) begin
        we         = 1'b1;
        wd.st      = ST_INCOMPLETE;
        wd.cnt     = 8'd1;
        wd.probe_t = cmd_r.now_ticks;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r    <= S_CLEAR;
      idx_r    <= '0;
      count_r  <= '0;
      outv_r   <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        st_r[i] <= ST_FREE;
      end
    end else begin
      if (outv_r && out_ready) begin
        outv_r <= 1'b0;
      end
      unique case (fsm_r)
        S_CLEAR: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == (IW+1)'(ENTRIES-1)) begin
            fsm_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            cmd_r    <= q_word;
            rsp_r    <= '0;
            idx_r    <= '0;
            hit_ok_r <= 1'b0;
            lru_ok_r <= 1'b0;
            if (q_word.command == CMD_SWEEP) begin
              fsm_r <= S_SWEEP;
            end else if (q_word.command == CMD_RSVD) begin
              fsm_r <= S_DONE;
            end else begin
              fsm_r <= S_LOOK;
            end
          end
        end
        // lookup: memory read issued this cycle, checked next
        S_LOOK: begin
          fsm_r <= S_LOOKW;
        end
        S_LOOKW: begin
          if (st_r[idx] != ST_FREE && rd_r.ip == cmd_r.target_ip) begin
            hit_ok_r <= 1'b1;
            hit_r    <= idx;
            fsm_r    <= S_ACT;
          end else if (idx_r == (IW+1)'(ENTRIES-1)) begin
            idx_r <= '0;
            fsm_r <= S_ALLOC;
          end else begin
            idx_r <= idx_r + 1'b1;
            fsm_r <= S_LOOK;
          end
        end
        S_ACT: begin
          fsm_r <= S_CREATE;
          tgt_r <= hit_r;
        end
        S_ALLOC: begin
          fsm_r <= S_ALLOCW;
        end
        S_ALLOCW: begin
          if (st_r[idx] == ST_FREE ||
              (st_r[idx] == ST_REACHABLE && !rd_fresh) ||
              (st_r[idx] == ST_FAILED && rd_fail_old)) begin
            if (st_r[idx] != ST_FREE) begin
              st_r[idx] <= ST_FREE;
              count_r   <= count_r - 1'b1;
            end
            tgt_r    <= idx;
            hit_ok_r <= 1'b0;
            fsm_r    <= S_CREATE;
          end else begin
            if (st_r[idx] == ST_REACHABLE && (!lru_ok_r || rd_r.used_t < lru_t_r)) begin
              lru_ok_r <= 1'b1;
              lru_r    <= idx;
              lru_t_r  <= rd_r.used_t;
            end
            if (idx_r == (IW+1)'(ENTRIES-1)) begin
              fsm_r <= S_LRU;
            end else begin
              idx_r <= idx_r + 1'b1;
              fsm_r <= S_ALLOC;
            end
          end
        end
        S_LRU: begin
          if (lru_ok_r) begin
            st_r[lru_r] <= ST_FREE;
            count_r     <= count_r - 1'b1;
            tgt_r       <= lru_r;
            hit_ok_r    <= 1'b0;
            fsm_r       <= S_CREATE;
          end else begin
            rsp_r.table_full <= 1'b1;
            fsm_r            <= S_DONE;
          end
        end
        // apply the command to slot tgt_r; rd_r holds it when hit
        S_CREATE: begin
          if (hit_ok_r) begin
            if (cmd_r.command == CMD_LEARN) begin
              fsm_r <= S_DONE;
              if (!rd_same_mac) begin
                st_r[tgt_r] <= ST_REACHABLE;
              end
            end else if (st_r[tgt_r] == ST_REACHABLE) begin
              if (rd_fresh) begin
                rsp_r.resolved     <= 1'b1;
                rsp_r.resolved_mac <= rd_r.mac;
                fsm_r              <= S_DONE;
              end else begin
                // free, then allocate fresh
                st_r[tgt_r] <= ST_FREE;
                count_r     <= count_r - 1'b1;
                idx_r       <= '0;
                lru_ok_r    <= 1'b0;
                hit_ok_r    <= 1'b0;
                fsm_r       <= S_ALLOC;
              end
            end else if (st_r[tgt_r] == ST_INCOMPLETE) begin
              fsm_r <= S_DONE;
              if (rd_probe_due) begin
                if (rd_below_limit) begin
                  rsp_r.send_probe <= 1'b1;
                end else begin
                  st_r[tgt_r] <= ST_FAILED;
                end
              end
            end else begin
              fsm_r <= S_DONE;
              if (rd_fail_old) begin
                st_r[tgt_r]      <= ST_INCOMPLETE;
                rsp_r.send_probe <= 1'b1;
              end
            end
          end else begin
            // new slot
            fsm_r   <= S_DONE;
            count_r <= count_r + 1'b1;
            if (cmd_r.command == CMD_LEARN) begin
              st_r[tgt_r] <= ST_REACHABLE;
            end else begin
              st_r[tgt_r]      <= ST_INCOMPLETE;
              rsp_r.send_probe <= 1'b1;
            end
          end
        end
        S_SWEEP: begin
          fsm_r <= S_SWEEPW;
        end
        S_SWEEPW: begin
          if ((st_r[idx] == ST_REACHABLE && !rd_fresh) ||
              (st_r[idx] == ST_FAILED && rd_fail_old)) begin
            st_r[idx] <= ST_FREE;
            count_r   <= count_r - 1'b1;
          end
          if (idx_r == (IW+1)'(ENTRIES-1)) begin
            fsm_r <= S_DONE;
          end else begin
            idx_r <= idx_r + 1'b1;
            fsm_r <= S_SWEEP;
          end
        end
        S_DONE: begin
          rsp_r.live_entries <= 7'(count_r);
          outv_r             <= 1'b1;
          fsm_r              <= S_IDLE;
        end
        default: fsm_r <= S_IDLE;
      endcase
    end
  end
endmodule

### design/arp_neighbor_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_neighbor_cache: IPv4 to MAC neighbor table with aging and LRU
// Front queue takes command words; back engine walks the slot table.
// ----------------------------------------------------------------------------
//  channel | handshake          | word
//  in_     | in_valid/in_ready  | command, target_ip, learned_mac, now_ticks
//  out_    | out_valid/out_ready| resolved, resolved_mac, send_probe, ...
//  cfg_    | cfg_we             | cfg_index, cfg_data (48 bits)
//
// Each slot walked takes a read of the slot memory and a check of the
// registered word. Lookup walks up to ENTRIES slots, allocation up to
// another ENTRIES, and control states lead on from pop to out_valid. A
// sweep walks all ENTRIES slots.
// Reset: after rst_n the engine clears the slot memory slot by slot
// before it takes a word. The two-word front queue parts the channels so
// input is still taken while a result waits on out_ready; the engine holds
// in idle until its result is taken, and in_ready drops once the queue fills.
// ----------------------------------------------------------------------------
module arp_neighbor_cache #(
  parameter int ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_target_ip,
  input  logic [47:0] in_learned_mac,
  input  logic [63:0] in_now_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_resolved,
  output logic [47:0] out_resolved_mac,
  output logic        out_send_probe,
  output logic        out_table_full,
  output logic [6:0]  out_live_entries,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  import anc_pkg::*;

  logic [47:0] lifetime_r, interval_r, holdoff_r;
  logic [7:0]  limit_r;
  logic        q_valid, q_pop;
  cmd_word_t   q_word;
  rsp_word_t   rsp;

  // hold configuration; write only while idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifetime_r <= 48'd30000000;
      interval_r <= 48'd1000000;
      holdoff_r  <= 48'd10000000;
      limit_r    <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LIFETIME: lifetime_r <= cfg_data;
        CFG_INTERVAL: interval_r <= cfg_data;
        CFG_HOLDOFF:  holdoff_r  <= cfg_data;
        CFG_LIMIT:    limit_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  anc_front #(.DEPTH(2)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_command, .in_target_ip,
    .in_learned_mac, .in_now_ticks, .q_valid, .q_pop, .q_word
  );

  anc_back #(.ENTRIES(ENTRIES)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_word,
    .lifetime(lifetime_r), .interval(interval_r), .holdoff(holdoff_r),
    .limit(limit_r), .out_valid, .out_ready, .out_word(rsp)
  );

  assign out_resolved     = rsp.resolved;
  assign out_resolved_mac = rsp.resolved_mac;
  assign out_send_probe   = rsp.send_probe;
  assign out_table_full   = rsp.table_full;
  assign out_live_entries = rsp.live_entries;
endmodule

### dv/arp_neighbor_cache_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_neighbor_cache_tb: self-checking bench for the ARP neighbor cache
// A table of directed command words runs first, then several random phases
// under different aging settings and idling patterns. Every accepted command
// word is run through a local model of the slot table and the predicted
// response word, or the one typed in its row, is queued; each response the
// block hands back is compared against the oldest queued prediction.
// ----------------------------------------------------------------------------
module arp_neighbor_cache_tb;
  import anc_pkg::*;

  localparam int          SLOTS       = 64;
  localparam int          N_DIR       = 14;
  localparam int          N_PHASE     = 8;
  localparam int          PHASE_WORDS = 210;
  localparam int          DRAIN       = 400;
  localparam int          HOLD_CYCLES = 2500;
  localparam longint      LIMIT       = 3000000;
  localparam logic [47:0] MAX48       = 48'hFFFF_FFFF_FFFF;
  localparam logic [63:0] MAX64       = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_command;
  logic [31:0] in_target_ip;
  logic [47:0] in_learned_mac;
  logic [63:0] in_now_ticks;
  logic        out_valid;
  logic        out_ready;
  logic        out_resolved;
  logic [47:0] out_resolved_mac;
  logic        out_send_probe;
  logic        out_table_full;
  logic [6:0]  out_live_entries;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [47:0] cfg_data;

  always #1 clk = ~clk;

  arp_neighbor_cache i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_target_ip    (in_target_ip),
    .in_learned_mac  (in_learned_mac),
    .in_now_ticks    (in_now_ticks),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_resolved    (out_resolved),
    .out_resolved_mac(out_resolved_mac),
    .out_send_probe  (out_send_probe),
    .out_table_full  (out_table_full),
    .out_live_entries(out_live_entries),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Local model of the neighbor table
  // --------------------------------------------------------------------------
  logic [47:0] life_span, probe_gap, fail_hold;
  logic [7:0]  probe_max;

  logic [1:0]  nc_st   [SLOTS];
  logic [31:0] nc_ip   [SLOTS];
  logic [47:0] nc_mac  [SLOTS];
  logic [63:0] nc_conf [SLOTS];
  logic [63:0] nc_prb  [SLOTS];
  logic [63:0] nc_used [SLOTS];
  logic [7:0]  nc_cnt  [SLOTS];
  int          nc_live;

  // A stored time later than now counts as expired.
  function automatic bit lapsed(logic [63:0] now, logic [63:0] then_t, logic [47:0] span);
    return (now < then_t) || ((now - then_t) >= {16'd0, span});
  endfunction

  function automatic void wipe_slot(int s);
    nc_st[s]   = ST_FREE;
    nc_ip[s]   = '0;
    nc_mac[s]  = '0;
    nc_conf[s] = '0;
    nc_prb[s]  = '0;
    nc_used[s] = '0;
    nc_cnt[s]  = '0;
  endfunction

  function automatic void evict_slot(int s);
    if (nc_st[s] != ST_FREE) begin
      wipe_slot(s);
      nc_live--;
    end
  endfunction

  function automatic void table_reset();
    life_span = 48'd30000000;
    probe_gap = 48'd1000000;
    fail_hold = 48'd10000000;
    probe_max = 8'd3;
    for (int i = 0; i < SLOTS; i++) wipe_slot(i);
    nc_live = 0;
  endfunction

  function automatic int find_ip(logic [31:0] ip);
    for (int i = 0; i < SLOTS; i++)
      if (nc_st[i] != ST_FREE && nc_ip[i] == ip) return i;
    return -1;
  endfunction

  // First free or expired slot wins; else the least recently used reachable one.
  function automatic int pick_slot(logic [63:0] now);
    int lru;
    lru = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (nc_st[i] == ST_FREE) return i;
      if ((nc_st[i] == ST_REACHABLE && lapsed(now, nc_conf[i], life_span)) ||
          (nc_st[i] == ST_FAILED && lapsed(now, nc_prb[i], fail_hold))) begin
        evict_slot(i);
        return i;
      end
      if (nc_st[i] == ST_REACHABLE && (lru < 0 || nc_used[i] < nc_used[lru])) lru = i;
    end
    if (lru >= 0) evict_slot(lru);
    return lru;
  endfunction

  function automatic int open_entry(logic [31:0] ip, logic [63:0] now);
    int s;
    s = pick_slot(now);
    if (s < 0) return -1;
    wipe_slot(s);
    nc_ip[s]   = ip;
    nc_st[s]   = ST_INCOMPLETE;
    nc_used[s] = now;
    nc_live++;
    return s;
  endfunction

  function automatic void mark_probe(int s, logic [63:0] now);
    nc_prb[s] = now;
    nc_cnt[s] = nc_cnt[s] + 8'd1;
  endfunction

  function automatic rsp_word_t predict_rsp(cmd_word_t w);
    rsp_word_t r;
    int s;
    r = '0;
    case (w.command)
      CMD_RESOLVE: begin
        s = find_ip(w.target_ip);
        if (s >= 0 && nc_st[s] == ST_REACHABLE &&
            !lapsed(w.now_ticks, nc_conf[s], life_span)) begin
          nc_used[s]     = w.now_ticks;
          r.resolved     = 1'b1;
          r.resolved_mac = nc_mac[s];
        end else if (s < 0 || nc_st[s] == ST_REACHABLE) begin
          // unknown address, or a stale mapping that is dropped first
          if (s >= 0) evict_slot(s);
          s = open_entry(w.target_ip, w.now_ticks);
          if (s < 0) r.table_full = 1'b1;
          else begin
            mark_probe(s, w.now_ticks);
            r.send_probe = 1'b1;
          end
        end else if (nc_st[s] == ST_INCOMPLETE) begin
          if (lapsed(w.now_ticks, nc_prb[s], probe_gap)) begin
            if (nc_cnt[s] < probe_max) begin
              mark_probe(s, w.now_ticks);
              r.send_probe = 1'b1;
            end else begin
              nc_st[s]  = ST_FAILED;
              nc_prb[s] = w.now_ticks;
            end
          end
        end else if (lapsed(w.now_ticks, nc_prb[s], fail_hold)) begin
          nc_st[s]  = ST_INCOMPLETE;
          nc_cnt[s] = '0;
          mark_probe(s, w.now_ticks);
          r.send_probe = 1'b1;
        end
      end
      CMD_LEARN: begin
        s = find_ip(w.target_ip);
        if (s >= 0 && nc_st[s] == ST_REACHABLE && nc_mac[s] == w.learned_mac) begin
          nc_conf[s] = w.now_ticks;
          nc_used[s] = w.now_ticks;
        end else begin
          if (s < 0) s = open_entry(w.target_ip, w.now_ticks);
          if (s < 0) r.table_full = 1'b1;
          else begin
            nc_mac[s]  = w.learned_mac;
            nc_st[s]   = ST_REACHABLE;
            nc_cnt[s]  = '0;
            nc_conf[s] = w.now_ticks;
            nc_used[s] = w.now_ticks;
          end
        end
      end
      CMD_SWEEP: begin
        for (int i = 0; i < SLOTS; i++)
          if ((nc_st[i] == ST_REACHABLE && lapsed(w.now_ticks, nc_conf[i], life_span)) ||
              (nc_st[i] == ST_FAILED && lapsed(w.now_ticks, nc_prb[i], fail_hold)))
            evict_slot(i);
      end
      default: ;
    endcase
    r.live_entries = nc_live[6:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Response checking
  // --------------------------------------------------------------------------
  rsp_word_t pending_rsp[$];
  int        mismatches = 0;
  int        snd_pct    = 0;   // chance in percent that the sender idles a cycle
  int        rcv_pct    = 0;   // chance in percent that the receiver stalls a cycle
  bit        hold_req   = 1'b0;
  longint    cycles     = 0;

  task automatic flag_bad(string what, rsp_word_t exp_w, rsp_word_t got_w);
    mismatches++;
    if (mismatches <= 10)
      $display("%t mismatch (%s): exp res=%0b mac=%h probe=%0b full=%0b live=%0d",
               $realtime, what, exp_w.resolved, exp_w.resolved_mac, exp_w.send_probe,
               exp_w.table_full, exp_w.live_entries,
               " | got res=%0b mac=%h probe=%0b full=%0b live=%0d",
               got_w.resolved, got_w.resolved_mac, got_w.send_probe,
               got_w.table_full, got_w.live_entries);
  endtask

  // Sample the response channel at the edge; drive out_ready for the next one.
  always @(posedge clk) begin
    rsp_word_t got_w, exp_w;
    int        hold_left;
    if (rst_n && out_valid && out_ready) begin
      got_w = '{out_resolved, out_resolved_mac, out_send_probe, out_table_full,
                out_live_entries};
      if (pending_rsp.size() == 0) flag_bad("unexpected word", '0, got_w);
      else begin
        exp_w = pending_rsp.pop_front();
        if (got_w !== exp_w) flag_bad("field", exp_w, got_w);
      end
    end
    // a long hold-off lets the front queue fill and back-pressure the input
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rcv_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [63:0] now;
    bit          typed;   // expected word written out in the row
    rsp_word_t   rsp;
  } dir_row_t;

  // Expected words typed in only for rows that follow from reset directly.
  dir_row_t dir_tbl[N_DIR] = '{
    '{CMD_RESOLVE, 32'h0,         48'h0,   64'd0,  1'b1, '{1'b0, 48'h0, 1'b1, 1'b0, 7'd1}},
    '{CMD_RESOLVE, 32'h0,         48'h0,   64'd0,  1'b1, '{1'b0, 48'h0, 1'b0, 1'b0, 7'd1}},
    '{CMD_LEARN,   32'hFFFF_FFFF, MAX48,   64'd5,  1'b1, '{1'b0, 48'h0, 1'b0, 1'b0, 7'd2}},
    '{CMD_RESOLVE, 32'hFFFF_FFFF, 48'h0,   64'd6,  1'b1, '{1'b1, MAX48, 1'b0, 1'b0, 7'd2}},
    '{CMD_LEARN,   32'hFFFF_FFFF, MAX48,   64'd7,  1'b0, '0},
    '{CMD_LEARN,   32'h0,  48'h1234_5678_9ABC, 64'd10, 1'b0, '0},
    '{CMD_RESOLVE, 32'h0,         48'h0,   MAX64,  1'b0, '0},
    '{CMD_RESOLVE, 32'hFFFF_FFFF, MAX48,   64'd3,  1'b0, '0},
    '{CMD_RESOLVE, 32'hA5A5_5A5A, 48'h0,   64'd100, 1'b0, '0},
    '{CMD_RESOLVE, 32'hA5A5_5A5A, 48'h0,   64'd1000100, 1'b0, '0},
    '{CMD_RESOLVE, 32'hA5A5_5A5A, 48'h0,   64'd2000100, 1'b0, '0},
    '{CMD_RESOLVE, 32'hA5A5_5A5A, 48'h0,   64'd3000100, 1'b0, '0},
    '{CMD_RESOLVE, 32'hA5A5_5A5A, 48'h0,   64'd13000100, 1'b0, '0},
    '{CMD_SWEEP,   32'h0,         MAX48,   MAX64,  1'b0, '0}
  };

  // Offer one command word; predict at the edge it is taken, then idle at random when snd_pct asks.
  task automatic push_word(cmd_word_t w, bit typed, rsp_word_t typed_rsp);
    rsp_word_t r;
    in_valid       <= 1'b1;
    in_command     <= w.command;
    in_target_ip   <= w.target_ip;
    in_learned_mac <= w.learned_mac;
    in_now_ticks   <= w.now_ticks;
    do @(posedge clk); while (!in_ready);
    r = predict_rsp(w);
    pending_rsp.push_back(typed ? typed_rsp : r);
    if (snd_pct > 0 && $urandom_range(0, 99) < snd_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < snd_pct);
    end
  endtask

  // Drop valid, let every response come back and the engine settle.
  task automatic drain_all();
    in_valid <= 1'b0;
    while (pending_rsp.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // Write all four registers on back-to-back edges, then release the port.
  task automatic program_regs(logic [47:0] lt, logic [47:0] iv, logic [47:0] ho,
                              logic [7:0] lim);
    logic [47:0] vals[4];
    vals = '{lt, iv, ho, {40'd0, lim}};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we    <= 1'b0;
    life_span = lt;
    probe_gap = iv;
    fail_hold = ho;
    probe_max = lim;
    @(posedge clk);
  endtask

  initial begin
    cmd_word_t   w;
    logic [47:0] ph_life [N_PHASE];
    logic [47:0] ph_gap  [N_PHASE];
    logic [47:0] ph_hold [N_PHASE];
    logic [7:0]  ph_lim  [N_PHASE];
    int          ph_step [N_PHASE];
    logic [63:0] tnow;
    logic [31:0] ip_base;
    logic [15:0] mac_hi;
    int          pick;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_command     = CMD_RESOLVE;
    in_target_ip   = '0;
    in_learned_mac = '0;
    in_now_ticks   = '0;
    out_ready      = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_LIFETIME;
    cfg_data       = '0;
    table_reset();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows at full rate
    for (int i = 0; i < N_DIR; i++) begin
      w = '{dir_tbl[i].cmd, dir_tbl[i].ip, dir_tbl[i].mac, dir_tbl[i].now};
      push_word(w, dir_tbl[i].typed, dir_tbl[i].rsp);
    end

    // aging settings per phase: short spans age often, extremes at both ends
    ph_life = '{48'd200, 48'd0, MAX48, 48'd500, 48'd30000000, 48'd150, 48'd0, 48'd80};
    ph_gap  = '{48'd30,  48'd0, MAX48, 48'd10,  48'd1000000,  48'd5,   MAX48, 48'd25};
    ph_hold = '{48'd100, 48'd0, MAX48, 48'd40,  48'd10000000, 48'd300, 48'd60, 48'd60};
    ph_lim  = '{8'd3,    8'd0,  8'd255, 8'd1,   8'd3,         8'd255,  8'd1,  8'd2};
    ph_step = '{25,      10,    1000,   40,     3000000,      20,      15,    20};

    for (int p = 0; p < N_PHASE; p++) begin
      drain_all();
      program_regs(ph_life[p], ph_gap[p], ph_hold[p], ph_lim[p]);
      // idling: none, sender, receiver, both
      case (p % 4)
        0: begin snd_pct = 0;  rcv_pct = 0;  end
        1: begin snd_pct = 83; rcv_pct = 0;  end
        2: begin snd_pct = 0;  rcv_pct = 83; end
        default: begin snd_pct = 32; rcv_pct = 32; end
      endcase
      if (p == 0) hold_req = 1'b1;
      tnow    = {$urandom, $urandom};
      ip_base = $urandom;
      mac_hi  = 16'($urandom);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // mostly advance time; now and then step back or jump far
        pick = $urandom_range(0, 99);
        if (pick < 3) tnow = tnow - $urandom_range(0, ph_step[p] * 4);
        else if (pick < 5) tnow = {$urandom, $urandom};
        else tnow = tnow + $urandom_range(0, ph_step[p]);
        w.now_ticks = tnow;
        // a pool of 80 addresses overfills the 64 slots
        w.target_ip = ($urandom_range(0, 15) == 0) ? $urandom
                                                   : ip_base ^ $urandom_range(0, 79);
        // a fixed mac per address makes most learns plain confirmations
        w.learned_mac = ($urandom_range(0, 3) == 0) ? 48'({$urandom, $urandom})
                                                    : {mac_hi, w.target_ip};
        pick = $urandom_range(0, 99);
        if (pick < 55) w.command = CMD_RESOLVE;
        else if (pick < 90) w.command = CMD_LEARN;
        else if (pick < 97) w.command = CMD_SWEEP;
        else w.command = CMD_RSVD;
        push_word(w, 1'b0, '0);
      end
    end

    drain_all();
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
